// ----- design/btwc_pkg.sv -----
// ----------------------------------------------------------------------------
// btwc_pkg
// Shared types, operation codes, register indexes and saturation helpers for
// the boosted tree window classifier.
// ----------------------------------------------------------------------------
package btwc_pkg;

  // Operation codes carried in the op field of an input word.
  localparam logic [2:0] OP_NODE   = 3'd0;
  localparam logic [2:0] OP_WEIGHT = 3'd1;
  localparam logic [2:0] OP_CODE   = 3'd2;
  localparam logic [2:0] OP_COST   = 3'd3;
  localparam logic [2:0] OP_SAMPLE = 3'd4;
  localparam logic [2:0] OP_EVAL   = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] REG_NUM_TREES    = 3'd0;
  localparam logic [2:0] REG_NUM_CLASSES  = 3'd1;
  localparam logic [2:0] REG_CASCADE_THR  = 3'd2;
  localparam logic [2:0] REG_MIN_SCORE    = 3'd3;
  localparam logic [2:0] REG_MODEL_HEIGHT = 3'd4;
  localparam logic [2:0] REG_MODEL_WIDTH  = 3'd5;
  localparam logic [2:0] REG_STRIDE       = 3'd6;
  localparam logic [2:0] REG_SHRINK       = 3'd7;

  // Iterative divider widths: dividend and divisor.
  localparam int DNW = 17;
  localparam int DDW = 14;

  typedef struct packed {
    logic [2:0]         op;
    logic [18:0]        index;
    logic [15:0]        feature_id;
    logic signed [31:0] threshold;
    logic [4:0]         child_index;
    logic [4:0]         leaf_class;
    logic signed [31:0] value;
    logic [9:0]         window_row;
    logic [9:0]         window_col;
  } in_word_t;

  typedef struct packed {
    logic               detected;
    logic [4:0]         class_label;
    logic signed [31:0] score;
    logic [15:0]        box_x;
    logic [15:0]        box_y;
    logic [10:0]        trees_used;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] value;
  } cfg_word_t;

  typedef struct packed {
    logic [15:0]        feature_id;
    logic signed [31:0] threshold;
    logic [4:0]         child_index;
    logic [4:0]         leaf_class;
  } node_t;

  // Saturate a 49-bit sum to 40 bits.
  function automatic logic signed [39:0] sat40(input logic signed [48:0] x);
    logic signed [39:0] r;
    if ((&x[48:39]) || !(|x[48:39])) r = x[39:0];
    else if (x[48]) r = {1'b1, {39{1'b0}}};
    else r = {1'b0, {39{1'b1}}};
    return r;
  endfunction

  // Saturate a 65-bit difference to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
    logic signed [31:0] r;
    if ((&x[64:31]) || !(|x[64:31])) r = x[31:0];
    else if (x[64]) r = {1'b1, {31{1'b0}}};
    else r = {1'b0, {31{1'b1}}};
    return r;
  endfunction

endpackage

// ----- design/btwc_stream_if.sv -----
// ----------------------------------------------------------------------------
// btwc_stream_if
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface btwc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/boosted_tree_window_classifier.sv -----
// ----------------------------------------------------------------------------
// boosted_tree_window_classifier
// Boosted decision tree cascade with a cost-sensitive multiclass margin.
// ----------------------------------------------------------------------------
// Usage. Words on in_chan either load a store (tree nodes, tree weights, code
// matrix, cost matrix, channel samples; one word a cycle while the block is
// idle, no result) or ask for the evaluation of one window, which gives one
// word on out_chan. cfg_chan writes the eight configuration registers and is
// always ready; the user must see that it is written only while the block
// is idle, which the block itself does not enforce.
// An evaluation first places the window with two divisions, then for each
// tree walks its split nodes (two divisions to decode the feature, one
// channel memory read per node), updates the margin of each of the K classes
// and forms the cost product over K by K entries, K being the class count,
// and finally registers the result. All divisions share one serial divider
// and the cost matrix has a single read port. One window is in work at a
// time; loads are taken whenever the block is idle.
// Reset clears the configuration to its defaults and the control state; the
// stores hold nothing defined until they are loaded.
// A finished result sits in the output register; the next word is accepted
// while it waits, and a second result waits until the first is taken.
// ----------------------------------------------------------------------------
module boosted_tree_window_classifier
  import btwc_pkg::*;
#(
  parameter int MAX_TREES     = 1024,
  parameter int MAX_NODES     = 32,
  parameter int MAX_CLASSES   = 16,
  parameter int FEAT_CHANNELS = 64,
  parameter int CHANNEL_ROWS  = 64,
  parameter int CHANNEL_COLS  = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  btwc_stream_if.sink   in_chan,
  btwc_stream_if.source out_chan,
  btwc_stream_if.sink   cfg_chan
);

  localparam int NODE_DEPTH = MAX_TREES * MAX_NODES;
  localparam int NAW        = $clog2(NODE_DEPTH);
  localparam int TIW        = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
  localparam int TCW        = $clog2(MAX_TREES + 1);
  localparam int NIW        = $clog2(MAX_NODES);
  localparam int SCW        = $clog2(MAX_NODES + 1);
  localparam int MAT_DEPTH  = MAX_CLASSES * MAX_CLASSES;
  localparam int MAW        = $clog2(MAT_DEPTH);
  localparam int CIW        = $clog2(MAX_CLASSES);
  localparam int KW         = $clog2(MAX_CLASSES + 1);
  localparam int CHAN_DEPTH = FEAT_CHANNELS * CHANNEL_ROWS * CHANNEL_COLS;
  localparam int CAW        = $clog2(CHAN_DEPTH);
  localparam int DCW        = $clog2(DNW + 1);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DIV    = 5'd1;
  localparam logic [4:0] S_POSR   = 5'd2;
  localparam logic [4:0] S_POSC   = 5'd3;
  localparam logic [4:0] S_TREE   = 5'd4;
  localparam logic [4:0] S_NODE   = 5'd5;
  localparam logic [4:0] S_FDIV1  = 5'd6;
  localparam logic [4:0] S_FDIV2  = 5'd7;
  localparam logic [4:0] S_SAMP   = 5'd8;
  localparam logic [4:0] S_LEAF   = 5'd9;
  localparam logic [4:0] S_MUL    = 5'd10;
  localparam logic [4:0] S_MADD   = 5'd11;
  localparam logic [4:0] S_COST0  = 5'd12;
  localparam logic [4:0] S_CMUL   = 5'd13;
  localparam logic [4:0] S_CACC   = 5'd14;
  localparam logic [4:0] S_TRACE  = 5'd15;
  localparam logic [4:0] S_FINISH = 5'd16;

  // Configuration registers.
  logic [10:0]        num_trees_r;
  logic [4:0]         num_classes_r;
  logic signed [31:0] cascade_thr_r;
  logic signed [31:0] min_score_r;
  logic [6:0]         model_h_r;
  logic [6:0]         model_w_r;
  logic [6:0]         stride_r;
  logic [6:0]         shrink_r;

  // Stores.
  node_t              node_mem [NODE_DEPTH];
  logic signed [31:0] wgt_mem  [MAX_TREES];
  logic signed [31:0] code_mem [MAT_DEPTH];
  logic signed [31:0] cost_mem [MAT_DEPTH];
  logic signed [31:0] chan_mem [CHAN_DEPTH];

  node_t              node_q;
  logic signed [31:0] wgt_q, code_q, cost_q, chan_q;

  logic           node_rd_en, wgt_rd_en, code_rd_en, cost_rd_en, chan_rd_en;
  logic [NAW-1:0] node_rd_addr;
  logic [TIW-1:0] wgt_rd_addr;
  logic [MAW-1:0] code_rd_addr, cost_rd_addr;
  logic [CAW-1:0] chan_rd_addr;

  // Sequencer state.
  logic [4:0]     state_r, state_nxt, div_ret_r, div_ret_nxt;
  logic [DNW-1:0] div_num_r, div_num_nxt, div_quo_r, div_quo_nxt;
  logic [DDW-1:0] div_den_r, div_den_nxt, div_rem_r, div_rem_nxt;
  logic [DCW-1:0] div_cnt_r, div_cnt_nxt;
  logic [9:0]     win_row_r, win_row_nxt, win_col_r, win_col_nxt;
  logic [DNW-1:0] posr_r, posr_nxt, posc_r, posc_nxt, ch_r, ch_nxt;
  logic [DDW-1:0] wh_r, wh_nxt;
  logic [6:0]     h_r, h_nxt;
  logic [KW-1:0]  k_lim_r, k_lim_nxt;
  logic [TCW-1:0] t_lim_r, t_lim_nxt, t_r, t_nxt, used_r, used_nxt;
  logic [NIW-1:0] k_r, k_nxt;
  logic [SCW-1:0] steps_r, steps_nxt;
  logic           oob_r, oob_nxt;
  logic [CIW-1:0] i_r, i_nxt, j_r, j_nxt, best_r, best_nxt;
  logic signed [63:0] prod_r, prod_nxt, acc_r, acc_nxt;
  logic signed [63:0] cost0_r, cost0_nxt, bestc_r, bestc_nxt;
  logic signed [55:0] p1_r, p1_nxt;
  logic signed [48:0] p2_r, p2_nxt;
  logic signed [31:0] trace_r, trace_nxt;
  logic [KW-1:0]      label_r, label_nxt;
  logic signed [39:0] margin_r [MAX_CLASSES];
  logic signed [39:0] margin_nxt [MAX_CLASSES];
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r, out_word_nxt;

  logic     in_acc;
  in_word_t in_w;

  assign in_w           = in_chan.data;
  assign in_chan.ready  = (state_r == S_IDLE);
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_word_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_trees_r   <= '0;
      num_classes_r <= 5'd2;
      cascade_thr_r <= '0;
      min_score_r   <= '0;
      model_h_r     <= 7'd1;
      model_w_r     <= 7'd1;
      stride_r      <= 7'd4;
      shrink_r      <= 7'd4;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.data.index)
        REG_NUM_TREES:    num_trees_r   <= cfg_chan.data.value[10:0];
        REG_NUM_CLASSES:  num_classes_r <= cfg_chan.data.value[4:0];
        REG_CASCADE_THR:  cascade_thr_r <= cfg_chan.data.value;
        REG_MIN_SCORE:    min_score_r   <= cfg_chan.data.value;
        REG_MODEL_HEIGHT: model_h_r     <= cfg_chan.data.value[6:0];
        REG_MODEL_WIDTH:  model_w_r     <= cfg_chan.data.value[6:0];
        REG_STRIDE:       stride_r      <= cfg_chan.data.value[6:0];
        REG_SHRINK:       shrink_r      <= cfg_chan.data.value[6:0];
      endcase
    end
  end

  // Node store: loaded from the input, read by the tree walk.
  always_ff @(posedge clk) begin
    if (in_acc && in_w.op == OP_NODE && 32'(in_w.index) < NODE_DEPTH) begin
      node_mem[NAW'(in_w.index)] <= '{in_w.feature_id, in_w.threshold,
                                     in_w.child_index, in_w.leaf_class};
    end
    if (node_rd_en) node_q <= node_mem[node_rd_addr];
  end

  // Tree weight store.
  always_ff @(posedge clk) begin
    if (in_acc && in_w.op == OP_WEIGHT && 32'(in_w.index) < MAX_TREES) begin
      wgt_mem[TIW'(in_w.index)] <= in_w.value;
    end
    if (wgt_rd_en) wgt_q <= wgt_mem[wgt_rd_addr];
  end

  // Code matrix store.
  always_ff @(posedge clk) begin
    if (in_acc && in_w.op == OP_CODE && 32'(in_w.index) < MAT_DEPTH) begin
      code_mem[MAW'(in_w.index)] <= in_w.value;
    end
    if (code_rd_en) code_q <= code_mem[code_rd_addr];
  end

  // Cost matrix store.
  always_ff @(posedge clk) begin
    if (in_acc && in_w.op == OP_COST && 32'(in_w.index) < MAT_DEPTH) begin
      cost_mem[MAW'(in_w.index)] <= in_w.value;
    end
    if (cost_rd_en) cost_q <= cost_mem[cost_rd_addr];
  end

  // Channel sample store.
  always_ff @(posedge clk) begin
    if (in_acc && in_w.op == OP_SAMPLE && 32'(in_w.index) < CHAN_DEPTH) begin
      chan_mem[CAW'(in_w.index)] <= in_w.value;
    end
    if (chan_rd_en) chan_q <= chan_mem[chan_rd_addr];
  end

  // Sequencer.
  always_comb begin
    logic [DDW:0]       div_shift;
    logic               div_ge;
    logic               div_start;
    logic [DNW-1:0]     div_num_in;
    logic [DDW-1:0]     div_den_in;
    logic [6:0]         shr, hc, wc;
    logic [17:0]        row, col;
    logic               oob;
    logic signed [31:0] sample;
    logic               go;
    logic [4:0]         nk;
    logic signed [39:0] m;
    logic signed [23:0] mh;
    logic signed [63:0] s;
    logic signed [47:0] u;
    logic signed [31:0] tr;
    logic [KW-1:0]      lab;

    state_nxt   = state_r;
    div_ret_nxt = div_ret_r;
    div_num_nxt = div_num_r;
    div_den_nxt = div_den_r;
    div_quo_nxt = div_quo_r;
    div_rem_nxt = div_rem_r;
    div_cnt_nxt = div_cnt_r;
    win_row_nxt = win_row_r;
    win_col_nxt = win_col_r;
    posr_nxt    = posr_r;
    posc_nxt    = posc_r;
    ch_nxt      = ch_r;
    wh_nxt      = wh_r;
    h_nxt       = h_r;
    k_lim_nxt   = k_lim_r;
    t_lim_nxt   = t_lim_r;
    t_nxt       = t_r;
    used_nxt    = used_r;
    k_nxt       = k_r;
    steps_nxt   = steps_r;
    oob_nxt     = oob_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    best_nxt    = best_r;
    prod_nxt    = prod_r;
    acc_nxt     = acc_r;
    cost0_nxt   = cost0_r;
    bestc_nxt   = bestc_r;
    p1_nxt      = p1_r;
    p2_nxt      = p2_r;
    trace_nxt   = trace_r;
    label_nxt   = label_r;
    margin_nxt  = margin_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;

    node_rd_en   = 1'b0;
    node_rd_addr = '0;
    wgt_rd_en    = 1'b0;
    wgt_rd_addr  = '0;
    code_rd_en   = 1'b0;
    code_rd_addr = '0;
    cost_rd_en   = 1'b0;
    cost_rd_addr = '0;
    chan_rd_en   = 1'b0;
    chan_rd_addr = '0;
    div_start    = 1'b0;
    div_num_in   = '0;
    div_den_in   = '0;

    shr    = (shrink_r == '0) ? 7'd1 : shrink_r;
    hc     = (model_h_r == '0) ? 7'd1 : model_h_r;
    wc     = (model_w_r == '0) ? 7'd1 : model_w_r;
    row    = 18'(div_rem_r) + 18'(posr_r);
    col    = 18'(div_quo_r) + 18'(posc_r);
    oob    = (32'(ch_r) >= FEAT_CHANNELS) || (32'(row) >= CHANNEL_ROWS) ||
             (32'(col) >= CHANNEL_COLS);
    sample = oob_r ? 32'sd0 : chan_q;
    go     = (sample < node_q.threshold);
    nk     = node_q.child_index - 5'(go);
    m      = margin_r[j_r];
    mh     = m[39:16];
    u      = prod_r[63:16];
    s      = acc_r + {{8{p1_r[55]}}, p1_r} + {{31{p2_r[48]}}, p2_r[48:16]};
    tr     = sat32(65'(cost0_r) - 65'(bestc_r));
    lab    = trace_r[31] ? KW'(1) : label_r;

    // One restoring division step a cycle.
    div_shift = {div_rem_r, div_num_r[DNW-1]};
    div_ge    = (div_shift >= {1'b0, div_den_r});

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_w.op == OP_EVAL) begin
          win_row_nxt = in_w.window_row;
          win_col_nxt = in_w.window_col;
          h_nxt       = hc;
          wh_nxt      = DDW'(hc) * DDW'(wc);
          if (num_classes_r < 5'd2) k_lim_nxt = KW'(2);
          else if (32'(num_classes_r) > MAX_CLASSES) k_lim_nxt = KW'(MAX_CLASSES);
          else k_lim_nxt = KW'(num_classes_r);
          t_lim_nxt = (32'(num_trees_r) > MAX_TREES) ? TCW'(MAX_TREES)
                                                     : TCW'(num_trees_r);
          div_start   = 1'b1;
          div_num_in  = DNW'(in_w.window_row) * DNW'(stride_r);
          div_den_in  = DDW'(shr);
          div_ret_nxt = S_POSR;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_cnt_r == DCW'(1)) state_nxt = div_ret_r;
      end
      S_POSR: begin
        posr_nxt    = div_quo_r;
        div_start   = 1'b1;
        div_num_in  = DNW'(win_col_r) * DNW'(stride_r);
        div_den_in  = DDW'(shr);
        div_ret_nxt = S_POSC;
        state_nxt   = S_DIV;
      end
      S_POSC: begin
        posc_nxt = div_quo_r;
        for (int n = 0; n < MAX_CLASSES; n++) margin_nxt[n] = '0;
        t_nxt = '0;
        if (t_lim_r == '0) begin
          trace_nxt = '0;
          label_nxt = KW'(1);
          used_nxt  = '0;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_TREE;
        end
      end
      S_TREE: begin
        k_nxt        = '0;
        steps_nxt    = '0;
        node_rd_en   = 1'b1;
        node_rd_addr = NAW'(32'(t_r[TIW-1:0]) * MAX_NODES);
        state_nxt    = S_NODE;
      end
      S_NODE: begin
        // A leaf, or the walk has run its full length.
        if (node_q.child_index == '0 || 32'(steps_r) >= MAX_NODES) begin
          state_nxt = S_LEAF;
        end else begin
          div_start   = 1'b1;
          div_num_in  = DNW'(node_q.feature_id);
          div_den_in  = wh_r;
          div_ret_nxt = S_FDIV1;
          state_nxt   = S_DIV;
        end
      end
      S_FDIV1: begin
        ch_nxt      = div_quo_r;
        div_start   = 1'b1;
        div_num_in  = DNW'(div_rem_r);
        div_den_in  = DDW'(h_r);
        div_ret_nxt = S_FDIV2;
        state_nxt   = S_DIV;
      end
      S_FDIV2: begin
        oob_nxt = oob;
        if (!oob) begin
          chan_rd_en   = 1'b1;
          chan_rd_addr = CAW'((32'(ch_r) * CHANNEL_ROWS + 32'(row)) * CHANNEL_COLS
                              + 32'(col));
        end
        state_nxt = S_SAMP;
      end
      S_SAMP: begin
        // Right child on a pass, left child one below it.
        if (32'(nk) >= MAX_NODES) begin
          state_nxt = S_LEAF;
        end else begin
          k_nxt        = NIW'(nk);
          steps_nxt    = steps_r + SCW'(1);
          node_rd_en   = 1'b1;
          node_rd_addr = NAW'(32'(t_r[TIW-1:0]) * MAX_NODES + 32'(nk));
          state_nxt    = S_NODE;
        end
      end
      S_LEAF: begin
        if (node_q.leaf_class != '0 && 32'(node_q.leaf_class) <= 32'(k_lim_r)) begin
          i_nxt        = '0;
          wgt_rd_en    = 1'b1;
          wgt_rd_addr  = t_r[TIW-1:0];
          code_rd_en   = 1'b1;
          code_rd_addr = MAW'(32'(node_q.leaf_class) - 1);
          state_nxt    = S_MUL;
        end else begin
          state_nxt = S_COST0;
        end
      end
      S_MUL: begin
        prod_nxt  = $signed({{32{wgt_q[31]}}, wgt_q}) *
                    $signed({{32{code_q[31]}}, code_q});
        state_nxt = S_MADD;
      end
      S_MADD: begin
        margin_nxt[i_r] = sat40(49'(margin_r[i_r]) + 49'(u));
        if (32'(i_r) == 32'(k_lim_r) - 1) begin
          state_nxt = S_COST0;
        end else begin
          i_nxt        = i_r + CIW'(1);
          code_rd_en   = 1'b1;
          code_rd_addr = MAW'((32'(i_r) + 1) * MAX_CLASSES +
                              32'(node_q.leaf_class) - 1);
          state_nxt    = S_MUL;
        end
      end
      S_COST0: begin
        i_nxt        = '0;
        j_nxt        = '0;
        acc_nxt      = '0;
        cost_rd_en   = 1'b1;
        cost_rd_addr = '0;
        state_nxt    = S_CMUL;
      end
      S_CMUL: begin
        // Split the margin into whole and fractional parts before scaling.
        p1_nxt    = $signed({{24{cost_q[31]}}, cost_q}) *
                    $signed({{32{mh[23]}}, mh});
        p2_nxt    = $signed({{17{cost_q[31]}}, cost_q}) *
                    $signed({33'd0, m[15:0]});
        state_nxt = S_CACC;
      end
      S_CACC: begin
        if (32'(j_r) == 32'(k_lim_r) - 1) begin
          // Row done: background cost, or the first minimum among objects.
          if (i_r == '0) begin
            cost0_nxt = s;
          end else if (i_r == CIW'(1) || s < bestc_r) begin
            bestc_nxt = s;
            best_nxt  = i_r;
          end
          acc_nxt = '0;
          if (32'(i_r) == 32'(k_lim_r) - 1) begin
            state_nxt = S_TRACE;
          end else begin
            i_nxt        = i_r + CIW'(1);
            j_nxt        = '0;
            cost_rd_en   = 1'b1;
            cost_rd_addr = MAW'((32'(i_r) + 1) * MAX_CLASSES);
            state_nxt    = S_CMUL;
          end
        end else begin
          j_nxt        = j_r + CIW'(1);
          acc_nxt      = s;
          cost_rd_en   = 1'b1;
          cost_rd_addr = MAW'(32'(i_r) * MAX_CLASSES + 32'(j_r) + 1);
          state_nxt    = S_CMUL;
        end
      end
      S_TRACE: begin
        trace_nxt = tr;
        label_nxt = KW'(best_r) + KW'(1);
        used_nxt  = t_r + TCW'(1);
        if (tr <= cascade_thr_r || t_r + TCW'(1) == t_lim_r) begin
          state_nxt = S_FINISH;
        end else begin
          t_nxt     = t_r + TCW'(1);
          state_nxt = S_TREE;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.detected    = (lab > KW'(1)) && (trace_r > min_score_r);
          out_word_nxt.class_label = 5'(lab);
          out_word_nxt.score       = trace_r;
          out_word_nxt.box_x       = 16'(17'(win_col_r) * 17'(stride_r));
          out_word_nxt.box_y       = 16'(17'(win_row_r) * 17'(stride_r));
          out_word_nxt.trees_used  = 11'(used_r);
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Divider load or step.
    if (div_start) begin
      div_num_nxt = div_num_in;
      div_den_nxt = div_den_in;
      div_quo_nxt = '0;
      div_rem_nxt = '0;
      div_cnt_nxt = DCW'(DNW);
    end else if (state_r == S_DIV) begin
      div_num_nxt = {div_num_r[DNW-2:0], 1'b0};
      div_quo_nxt = {div_quo_r[DNW-2:0], div_ge};
      div_rem_nxt = div_ge ? DDW'(div_shift - {1'b0, div_den_r}) : DDW'(div_shift);
      div_cnt_nxt = div_cnt_r - DCW'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
      div_ret_r   <= S_IDLE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      div_cnt_r   <= div_cnt_nxt;
      div_ret_r   <= div_ret_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    div_num_r  <= div_num_nxt;
    div_den_r  <= div_den_nxt;
    div_quo_r  <= div_quo_nxt;
    div_rem_r  <= div_rem_nxt;
    win_row_r  <= win_row_nxt;
    win_col_r  <= win_col_nxt;
    posr_r     <= posr_nxt;
    posc_r     <= posc_nxt;
    ch_r       <= ch_nxt;
    wh_r       <= wh_nxt;
    h_r        <= h_nxt;
    k_lim_r    <= k_lim_nxt;
    t_lim_r    <= t_lim_nxt;
    t_r        <= t_nxt;
    used_r     <= used_nxt;
    k_r        <= k_nxt;
    steps_r    <= steps_nxt;
    oob_r      <= oob_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    best_r     <= best_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    cost0_r    <= cost0_nxt;
    bestc_r    <= bestc_nxt;
    p1_r       <= p1_nxt;
    p2_r       <= p2_nxt;
    trace_r    <= trace_nxt;
    label_r    <= label_nxt;
    margin_r   <= margin_nxt;
    out_word_r <= out_word_nxt;
  end

  // The divider is never left running with its count spent.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> div_cnt_r != '0)
    else $error("divider running with zero count");

  // An accepted evaluation always takes the sequencer out of idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_w.op == OP_EVAL |=> state_r != S_IDLE)
    else $error("evaluation accepted but sequencer idle");

  // A result appears only when a window has finished.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FINISH)
    else $error("result raised outside finish");

  // The walk never counts past the node limit.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SAMP |-> 32'(steps_r) < MAX_NODES)
    else $error("tree walk overran node limit");

  // The tree count reported never exceeds the trees in use.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FINISH |-> used_r <= t_lim_r)
    else $error("trees used beyond limit");

endmodule
